// File: src/xmc_pkg.sv
// ---------------------------------------------------------------------------
// xmc_pkg: shared types and constants
// Character codes, request and status codes, receiver phases and the
// transaction structs used by the checksum receiver.
// ---------------------------------------------------------------------------
`default_nettype none

package xmc_pkg;

   localparam int BLOCK_BYTES_DEF = 128;

   localparam logic [7:0] CH_SOH = 8'd1;
   localparam logic [7:0] CH_EOT = 8'd4;
   localparam logic [7:0] CH_ACK = 8'd6;
   localparam logic [7:0] CH_NAK = 8'd21;

   localparam logic [7:0] ERR_LIMIT_RESET = 8'd10;
   localparam logic [7:0] ERR_COUNT_MAX   = 8'hff;
   localparam logic [8:0] COMPLEMENT_SUM  = 9'd255;

   typedef enum logic [1:0] {
      REQ_START = 2'd0,
      REQ_BYTE  = 2'd1,
      REQ_ABORT = 2'd2,
      REQ_NONE  = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      VERDICT_NONE   = 2'd0,
      VERDICT_ACCEPT = 2'd1,
      VERDICT_REJECT = 2'd2
   } verdict_type;

   typedef enum logic [1:0] {
      STATUS_IDLE    = 2'd0,
      STATUS_RUNNING = 2'd1,
      STATUS_DONE    = 2'd2,
      STATUS_FAILED  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_HUNT = 3'd1,
      PH_NUM  = 3'd2,
      PH_COMP = 3'd3,
      PH_DATA = 3'd4,
      PH_SUM  = 3'd5,
      PH_DONE = 3'd6,
      PH_FAIL = 3'd7
   } phase_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] rx_byte;
   } req_item_type;

   typedef struct packed {
      logic       send_valid;
      logic [7:0] send_byte;
      logic       data_valid;
      logic [7:0] data_byte;
      logic [6:0] data_offset;
      logic [1:0] block_verdict;
      logic [1:0] xfer_status;
   } rsp_item_type;

endpackage

`default_nettype wire

// File: src/xmc_req_if.sv
// ---------------------------------------------------------------------------
// xmc_req_if: request channel
// Valid/ready channel carrying one receiver event per transaction.
// ---------------------------------------------------------------------------
`default_nettype none

interface xmc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [7:0] rx_byte;

   modport source (output valid, output req_type, output rx_byte, input ready);
   modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

`default_nettype wire

// File: src/xmc_rsp_if.sv
// ---------------------------------------------------------------------------
// xmc_rsp_if: result channel
// Valid/ready channel carrying one receiver result per transaction.
// ---------------------------------------------------------------------------
`default_nettype none

interface xmc_rsp_if;
   logic       valid;
   logic       ready;
   logic       send_valid;
   logic [7:0] send_byte;
   logic       data_valid;
   logic [7:0] data_byte;
   logic [6:0] data_offset;
   logic [1:0] block_verdict;
   logic [1:0] xfer_status;

   modport source (
      output valid, output send_valid, output send_byte, output data_valid,
      output data_byte, output data_offset, output block_verdict,
      output xfer_status, input ready
   );
   modport sink (
      input valid, input send_valid, input send_byte, input data_valid,
      input data_byte, input data_offset, input block_verdict,
      input xfer_status, output ready
   );
endinterface

`default_nettype wire

// File: src/xmc_in_stage.sv
// ---------------------------------------------------------------------------
// xmc_in_stage: request input register
// Captures one request transaction and holds it until the protocol stage
// consumes it.
// ---------------------------------------------------------------------------
`default_nettype none

module xmc_in_stage
   import xmc_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   xmc_req_if.sink     req_chan,
   input  wire logic   pop,
   output logic        item_valid,
   output req_item_type item
);

   logic         valid_ff, valid_in;
   req_item_type item_ff;
   logic         accept;

   assign req_chan.ready = !valid_ff || pop;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (pop) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.req_type <= req_chan.req_type;
         item_ff.rx_byte  <= req_chan.rx_byte;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

// File: src/xmc_fsm.sv
// ---------------------------------------------------------------------------
// xmc_fsm: receiver protocol state machine
// Holds the transfer state and the error limit register, and works out the
// result of one request in a single pass.
// ---------------------------------------------------------------------------
`default_nettype none

module xmc_fsm
   import xmc_pkg::*;
#(
   parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data,
   input  wire logic        fire,
   input  wire req_item_type item,
   output rsp_item_type     result
);

   localparam int IDX_W = $clog2(BLOCK_BYTES);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BLOCK_BYTES - 1);

   phase_type        phase_ff, phase_in;
   logic [7:0]       last_good_ff, last_good_in;
   logic [7:0]       got_num_ff, got_num_in;
   logic [7:0]       sum_ff, sum_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]       err_ff, err_in;
   logic [7:0]       limit_ff;

   logic [7:0]       err_inc;
   logic [7:0]       limit_eff;
   logic             err_fail;
   logic             running;
   logic [IDX_W+6:0] idx_ext;
   logic [8:0]       pair_sum;

   assign err_inc   = (err_ff == ERR_COUNT_MAX) ? ERR_COUNT_MAX : err_ff + 8'd1;
   assign limit_eff = (limit_ff == 8'd0) ? 8'd1 : limit_ff;
   assign err_fail  = err_inc >= limit_eff;
   assign running   = (phase_ff >= PH_HUNT) && (phase_ff <= PH_SUM);
   assign idx_ext   = {7'd0, idx_ff};
   assign pair_sum  = {1'b0, got_num_ff} + {1'b0, item.rx_byte};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         last_good_ff <= 8'd0;
         got_num_ff   <= 8'd0;
         sum_ff       <= 8'd0;
         idx_ff       <= '0;
         err_ff       <= 8'd0;
      end else begin
         phase_ff     <= phase_in;
         last_good_ff <= last_good_in;
         got_num_ff   <= got_num_in;
         sum_ff       <= sum_in;
         idx_ff       <= idx_in;
         err_ff       <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= ERR_LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      last_good_in = last_good_ff;
      got_num_in   = got_num_ff;
      sum_in       = sum_ff;
      idx_in       = idx_ff;
      err_in       = err_ff;
      result       = '0;

      if (fire) begin
         unique case (req_code_type'(item.req_type))
            REQ_START: begin
               last_good_in       = 8'd0;
               got_num_in         = 8'd0;
               sum_in             = 8'd0;
               idx_in             = '0;
               err_in             = 8'd0;
               phase_in           = PH_HUNT;
               result.send_valid  = 1'b1;
               result.send_byte   = CH_NAK;
            end
            REQ_ABORT: begin
               if (running) begin
                  phase_in = PH_FAIL;
               end
            end
            REQ_BYTE: begin
               unique case (phase_ff)
                  PH_HUNT: begin
                     if (item.rx_byte == CH_SOH) begin
                        phase_in = PH_NUM;
                     end else if (item.rx_byte == CH_EOT) begin
                        result.send_valid = 1'b1;
                        result.send_byte  = CH_ACK;
                        phase_in          = PH_DONE;
                     end
                  end
                  PH_NUM: begin
                     got_num_in = item.rx_byte;
                     phase_in   = PH_COMP;
                  end
                  PH_COMP: begin
                     priority if (pair_sum != COMPLEMENT_SUM) begin
                        err_in            = err_inc;
                        result.send_valid = 1'b1;
                        result.send_byte  = CH_NAK;
                        phase_in          = err_fail ? PH_FAIL : PH_HUNT;
                     end else if (got_num_ff == last_good_ff + 8'd1) begin
                        sum_in   = 8'd0;
                        idx_in   = '0;
                        phase_in = PH_DATA;
                     end else if (got_num_ff == last_good_ff) begin
                        // duplicate of the last good block
                        result.send_valid = 1'b1;
                        result.send_byte  = CH_ACK;
                        phase_in          = PH_HUNT;
                     end else begin
                        err_in            = err_inc;
                        result.send_valid = 1'b1;
                        result.send_byte  = CH_NAK;
                        phase_in          = err_fail ? PH_FAIL : PH_HUNT;
                     end
                  end
                  PH_DATA: begin
                     result.data_valid  = 1'b1;
                     result.data_byte   = item.rx_byte;
                     result.data_offset = idx_ext[6:0];
                     sum_in             = sum_ff + item.rx_byte;
                     if (idx_ff == IDX_LAST) begin
                        phase_in = PH_SUM;
                     end else begin
                        idx_in = idx_ff + IDX_W'(1);
                     end
                  end
                  PH_SUM: begin
                     if (item.rx_byte == sum_ff) begin
                        err_in               = 8'd0;
                        last_good_in         = last_good_ff + 8'd1;
                        result.send_valid    = 1'b1;
                        result.send_byte     = CH_ACK;
                        result.block_verdict = VERDICT_ACCEPT;
                        phase_in             = PH_HUNT;
                     end else begin
                        err_in               = err_inc;
                        result.send_valid    = 1'b1;
                        result.send_byte     = CH_NAK;
                        result.block_verdict = VERDICT_REJECT;
                        phase_in             = err_fail ? PH_FAIL : PH_HUNT;
                     end
                  end
                  default: begin
                     // idle, done or failed: bytes are dropped
                  end
               endcase
            end
            default: begin
               // unknown request code is ignored
            end
         endcase

         unique case (phase_in)
            PH_IDLE: result.xfer_status = STATUS_IDLE;
            PH_DONE: result.xfer_status = STATUS_DONE;
            PH_FAIL: result.xfer_status = STATUS_FAILED;
            default: result.xfer_status = STATUS_RUNNING;
         endcase
      end
   end

endmodule

`default_nettype wire

// File: src/xmodem_checksum_receiver.sv
// ---------------------------------------------------------------------------
// xmodem_checksum_receiver: XMODEM receiver, 8-bit checksum
// Receiver side of XMODEM with 128-byte blocks and a modulo-256 checksum.
//
// Each req_chan transaction is one event: start, a byte from the line, or
// timeout/cancel. Each produces exactly one rsp_chan transaction carrying
// the reply byte to send (ACK/NAK), a provisional payload byte with its
// offset, a block verdict and the transfer status after the event.
// csr_wr_en/csr_wr_data set the consecutive-error limit (reset value 10);
// write it only while no transaction is in flight.
// The request register feeds the protocol logic, which loads the result
// register when it is empty or being taken. One transaction per cycle is
// sustained while rsp_chan does not stall.
// Reset (synchronous) empties both registers, sets the phase to idle and
// the error limit to 10. When rsp_chan stalls, the result is held and the
// request register still takes one more transaction before req_chan.ready
// drops; nothing is lost or repeated.
// ---------------------------------------------------------------------------
`default_nettype none

module xmodem_checksum_receiver
   import xmc_pkg::*;
#(
   parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   xmc_req_if.sink         req_chan,
   xmc_rsp_if.source       rsp_chan,
   input  wire logic       csr_wr_en,
   input  wire logic [7:0] csr_wr_data
);

   logic         item_valid;
   req_item_type item;
   logic         advance;
   rsp_item_type result;
   rsp_item_type rsp_ff;
   logic         rsp_valid_ff, rsp_valid_in;

   assign advance = item_valid && (!rsp_valid_ff || rsp_chan.ready);

   xmc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .pop        (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   xmc_fsm #(
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_fsm (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fire        (advance),
      .item        (item),
      .result      (result)
   );

   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.send_valid    = rsp_ff.send_valid;
   assign rsp_chan.send_byte     = rsp_ff.send_byte;
   assign rsp_chan.data_valid    = rsp_ff.data_valid;
   assign rsp_chan.data_byte     = rsp_ff.data_byte;
   assign rsp_chan.data_offset   = rsp_ff.data_offset;
   assign rsp_chan.block_verdict = rsp_ff.block_verdict;
   assign rsp_chan.xfer_status   = rsp_ff.xfer_status;

endmodule

`default_nettype wire

// File: bench/xmodem_checksum_receiver_test.sv
// ---------------------------------------------------------------------------
// xmodem_checksum_receiver_test: self-checking bench for the XMODEM receiver
// Drives start, line-byte, abort and unused request transactions through the
// request channel and predicts every result transaction in a scoreboard.
// The bench walks well-formed blocks, duplicates, bad headers, bad checksums,
// noise and aborts under several error limits. It also takes the error count
// up to a large limit. Both channels idle at random, and the result side
// holds off long enough to back up the request side.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module xmodem_checksum_receiver_test;
   import xmc_pkg::*;

   localparam int BLOCK_LEN   = BLOCK_BYTES_DEF;
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 80;
   localparam int RANDOM_ITEMS = 175;
   localparam logic [7:0] GIVE_UP_LIMIT = 8'd100;

   class reply_scoreboard;
      rsp_item_type expected_replies[$];
      int unsigned  mismatches;
      logic [7:0]   limit_reg;
      phase_type    phase;
      logic [7:0]   last_good;
      logic [7:0]   block_num;
      logic [7:0]   sum;
      int unsigned  offset;
      logic [7:0]   errors;
      rsp_item_type reply;

      function new();
         limit_reg  = ERR_LIMIT_RESET;
         phase      = PH_IDLE;
         last_good  = '0;
         block_num  = '0;
         sum        = '0;
         offset     = 0;
         errors     = '0;
         mismatches = 0;
      endfunction

      function void set_limit(logic [7:0] value);
         limit_reg = value;
      endfunction

      // one more consecutive error: NAK, and give up once the limit is hit
      function void note_error();
         logic [7:0] lim;
         lim = (limit_reg == 8'd0) ? 8'd1 : limit_reg;
         if (errors != ERR_COUNT_MAX) errors++;
         reply.send_valid = 1'b1;
         reply.send_byte  = CH_NAK;
         phase = (errors >= lim) ? PH_FAIL : PH_HUNT;
      endfunction

      function void note_request(logic [1:0] kind, logic [7:0] b);
         logic running;
         running = (phase >= PH_HUNT) && (phase <= PH_SUM);
         reply = '0;
         case (kind)
            REQ_START: begin
               last_good        = '0;
               block_num        = '0;
               sum              = '0;
               offset           = 0;
               errors           = '0;
               phase            = PH_HUNT;
               reply.send_valid = 1'b1;
               reply.send_byte  = CH_NAK;
            end
            REQ_ABORT: begin
               if (running) phase = PH_FAIL;
            end
            REQ_BYTE: begin
               if (running) begin
                  case (phase)
                     PH_HUNT: begin
                        if (b == CH_SOH) begin
                           phase = PH_NUM;
                        end else if (b == CH_EOT) begin
                           reply.send_valid = 1'b1;
                           reply.send_byte  = CH_ACK;
                           phase            = PH_DONE;
                        end
                     end
                     PH_NUM: begin
                        block_num = b;
                        phase     = PH_COMP;
                     end
                     PH_COMP: begin
                        if ({1'b0, block_num} + {1'b0, b} != COMPLEMENT_SUM) begin
                           note_error();
                        end else if (block_num == 8'(last_good + 8'd1)) begin
                           sum    = '0;
                           offset = 0;
                           phase  = PH_DATA;
                        end else if (block_num == last_good) begin
                           reply.send_valid = 1'b1;
                           reply.send_byte  = CH_ACK;
                           phase            = PH_HUNT;
                        end else begin
                           note_error();
                        end
                     end
                     PH_DATA: begin
                        reply.data_valid  = 1'b1;
                        reply.data_byte   = b;
                        reply.data_offset = 7'(offset);
                        sum = sum + b;
                        if (offset + 1 >= BLOCK_LEN) phase = PH_SUM;
                        else offset++;
                     end
                     default: begin
                        // checksum byte
                        if (b == sum) begin
                           errors              = '0;
                           last_good           = last_good + 8'd1;
                           reply.send_valid    = 1'b1;
                           reply.send_byte     = CH_ACK;
                           reply.block_verdict = VERDICT_ACCEPT;
                           phase               = PH_HUNT;
                        end else begin
                           reply.block_verdict = VERDICT_REJECT;
                           note_error();
                        end
                     end
                  endcase
               end
            end
            default: ;
         endcase
         case (phase)
            PH_IDLE: reply.xfer_status = STATUS_IDLE;
            PH_DONE: reply.xfer_status = STATUS_DONE;
            PH_FAIL: reply.xfer_status = STATUS_FAILED;
            default: reply.xfer_status = STATUS_RUNNING;
         endcase
         expected_replies.push_back(reply);
      endfunction

      function void compare(string field, logic [7:0] want, logic [7:0] got);
         if (want !== got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type want;
         if (expected_replies.size() == 0) begin
            $error("result transaction with nothing pending");
            mismatches++;
            return;
         end
         want = expected_replies.pop_front();
         compare("send_valid", want.send_valid, got.send_valid);
         compare("send_byte", want.send_byte, got.send_byte);
         compare("data_valid", want.data_valid, got.data_valid);
         compare("data_byte", want.data_byte, got.data_byte);
         compare("data_offset", want.data_offset, got.data_offset);
         compare("block_verdict", want.block_verdict, got.block_verdict);
         compare("xfer_status", want.xfer_status, got.xfer_status);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [7:0]  csr_wr_data = '0;
   bit          sender_calm = 1'b0;
   bit          sink_calm = 1'b0;
   int unsigned offered = 0;
   int unsigned quiet = 0;
   reply_scoreboard board;

   xmc_req_if req ();
   xmc_rsp_if rsp ();

   xmodem_checksum_receiver dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req),
      .rsp_chan    (rsp),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // valid stays high between back-to-back transactions
   task automatic push_event(req_code_type kind, logic [7:0] b);
      int gap;
      gap = sender_calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid    <= 1'b1;
      req.req_type <= kind;
      req.rx_byte  <= b;
      do @(posedge clock); while (!req.ready);
      board.note_request(kind, b);
      offered++;
   endtask

   task automatic settle();
      req.valid <= 1'b0;
      while (board.expected_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_error_limit(logic [7:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.set_limit(value);
   endtask

   // header, payload cut short at stop_at, then checksum if the block is whole
   task automatic send_block(logic [7:0] num, bit keep_sum, int stop_at);
      logic [7:0] sum;
      logic [7:0] d;
      int         style;
      style = $urandom_range(0, 7);
      sum   = '0;
      push_event(REQ_BYTE, CH_SOH);
      push_event(REQ_BYTE, num);
      push_event(REQ_BYTE, ~num);
      for (int i = 0; i < BLOCK_LEN; i++) begin
         if (i == stop_at) return;
         case (style)
            0: d = 8'h00;
            1: d = 8'hff;
            default: d = 8'($urandom_range(0, 255));
         endcase
         push_event(REQ_BYTE, d);
         sum = sum + d;
      end
      push_event(REQ_BYTE, keep_sum ? sum : sum ^ (8'd1 << $urandom_range(0, 7)));
   endtask

   task automatic run_directed();
      push_event(REQ_BYTE, CH_SOH);       // byte while idle
      push_event(REQ_ABORT, 8'h00);       // timeout while idle
      push_event(REQ_NONE, 8'hff);
      push_event(REQ_START, 8'hff);
      push_event(REQ_BYTE, 8'h00);        // noise while hunting
      push_event(REQ_BYTE, 8'hff);
      push_event(REQ_NONE, 8'h00);
      push_event(REQ_BYTE, CH_SOH);       // previous block number
      push_event(REQ_BYTE, 8'h00);
      push_event(REQ_BYTE, 8'hff);
      push_event(REQ_BYTE, CH_SOH);       // bad complement
      push_event(REQ_BYTE, 8'h05);
      push_event(REQ_BYTE, 8'h00);
      push_event(REQ_BYTE, CH_SOH);       // unexpected number
      push_event(REQ_BYTE, 8'h07);
      push_event(REQ_BYTE, 8'hf8);
      push_event(REQ_BYTE, CH_SOH);
      push_event(REQ_BYTE, 8'h01);
      push_event(REQ_BYTE, 8'hfe);
      push_event(REQ_BYTE, 8'hff);
      push_event(REQ_BYTE, 8'h00);
      push_event(REQ_START, 8'h00);       // restart in the middle of a block
      push_event(REQ_BYTE, CH_EOT);
      push_event(REQ_BYTE, CH_SOH);       // ignored once completed
      push_event(REQ_ABORT, 8'hff);
      push_event(REQ_START, 8'h00);
      push_event(REQ_ABORT, 8'h00);
      push_event(REQ_NONE, 8'h55);
   endtask

   task automatic run_random(int unsigned count);
      int unsigned stop;
      int          pick;
      logic [7:0]  n;
      stop = offered + count;
      push_event(REQ_START, 8'($urandom_range(0, 255)));
      while (offered < stop) begin
         if ($urandom_range(0, 15) == 0) sender_calm = !sender_calm;
         if (board.phase == PH_DONE || board.phase == PH_FAIL) begin
            if ($urandom_range(0, 3) == 0)
               push_event(req_code_type'($urandom_range(1, 3)), 8'($urandom_range(0, 255)));
            push_event(REQ_START, 8'($urandom_range(0, 255)));
         end
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            send_block(board.last_good + 8'd1, 1'b1, BLOCK_LEN);
         end else if (pick < 50) begin
            send_block(board.last_good + 8'd1, 1'b0, BLOCK_LEN);
         end else if (pick < 53) begin
            send_block(board.last_good + 8'd1, 1'b1, $urandom_range(0, BLOCK_LEN - 1));
            if ($urandom_range(0, 1) == 0) push_event(REQ_ABORT, 8'($urandom_range(0, 255)));
         end else if (pick < 63) begin
            n = board.last_good;
            push_event(REQ_BYTE, CH_SOH);
            push_event(REQ_BYTE, n);
            push_event(REQ_BYTE, ~n);
         end else if (pick < 71) begin
            n = 8'($urandom_range(0, 255));
            push_event(REQ_BYTE, CH_SOH);
            push_event(REQ_BYTE, n);
            push_event(REQ_BYTE, ~n ^ 8'($urandom_range(1, 255)));
         end else if (pick < 78) begin
            n = board.last_good + 8'd2 + 8'($urandom_range(0, 253));
            push_event(REQ_BYTE, CH_SOH);
            push_event(REQ_BYTE, n);
            push_event(REQ_BYTE, ~n);
         end else if (pick < 88) begin
            repeat ($urandom_range(1, 4)) push_event(REQ_BYTE, 8'($urandom_range(0, 255)));
         end else if (pick < 91) begin
            push_event(REQ_ABORT, 8'($urandom_range(0, 255)));
         end else if (pick < 94) begin
            push_event(REQ_NONE, 8'($urandom_range(0, 255)));
         end else if (pick < 96) begin
            push_event(REQ_START, 8'($urandom_range(0, 255)));
         end else begin
            push_event(REQ_BYTE, CH_EOT);
         end
      end
   endtask

   // error count climbs all the way to a large limit before the transfer fails
   task automatic run_give_up();
      logic [7:0] n;
      push_event(REQ_START, 8'h00);
      repeat (GIVE_UP_LIMIT) begin
         n = 8'($urandom_range(0, 255));
         push_event(REQ_BYTE, CH_SOH);
         push_event(REQ_BYTE, n);
         push_event(REQ_BYTE, n);
      end
      push_event(REQ_BYTE, CH_SOH);
   endtask

   initial begin
      logic [7:0] limits[5];
      limits = '{8'd1, 8'd3, 8'd0, 8'd2, 8'd10};
      board = new();
      req.valid    <= 1'b0;
      req.req_type <= REQ_NONE;
      req.rx_byte  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      settle();
      foreach (limits[i]) begin
         set_error_limit(limits[i]);
         run_random(RANDOM_ITEMS);
         settle();
      end
      set_error_limit(GIVE_UP_LIMIT);
      run_give_up();
      settle();
      if (board.mismatches == 0) begin
         $display("xmodem_checksum_receiver_test OK");
      end else begin
         $display("xmodem_checksum_receiver_test NOT OK");
      end
      $finish;
   end

   initial begin : result_sink
      int           gap;
      int unsigned  taken;
      rsp_item_type got;
      taken = 0;
      rsp.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if ($urandom_range(0, 31) == 0) sink_calm = !sink_calm;
         gap = sink_calm ? 0 : $urandom_range(0, 6);
         // long hold-off so the request side backs up
         if (taken == 300 || taken == 900) gap = HOLD_CYCLES;
         if (gap > 0) begin
            rsp.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (!rsp.valid);
         got.send_valid    = rsp.send_valid;
         got.send_byte     = rsp.send_byte;
         got.data_valid    = rsp.data_valid;
         got.data_byte     = rsp.data_byte;
         got.data_offset   = rsp.data_offset;
         got.block_verdict = rsp.block_verdict;
         got.xfer_status   = rsp.xfer_status;
         board.check_result(got);
         taken++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         quiet <= 0;
      end else if (quiet >= STALL_LIMIT) begin
         $display("xmodem_checksum_receiver_test NOT OK");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

endmodule

// File: xmodem_checksum_receiver.f
src/xmc_pkg.sv
src/xmc_req_if.sv
src/xmc_rsp_if.sv
src/xmc_in_stage.sv
src/xmc_fsm.sv
src/xmodem_checksum_receiver.sv
bench/xmodem_checksum_receiver_test.sv
